// ===== hw/rtl/ooktx_pkg.sv =====
package ooktx_pkg;

  localparam int unsigned SHORT_W    = 12;
  localparam int unsigned LONG_W     = 13;
  localparam int unsigned GAP_W      = 16;
  localparam int unsigned RPT_W      = 4;
  localparam int unsigned ID_W       = 26;
  localparam int unsigned DEV_W      = 4;
  localparam int unsigned FRAME_W    = 32;
  localparam int unsigned SEG_W      = 8;
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned WIN        = 6;

  localparam logic [SEG_W-1:0] SEG_HDR_HI    = 8'd0;
  localparam logic [SEG_W-1:0] SEG_HDR_LO    = 8'd1;
  localparam logic [SEG_W-1:0] SEG_FIRST_BIT = 8'd2;
  localparam logic [SEG_W-1:0] SEG_FOOTER    = 8'd130;
  localparam logic [SEG_W-1:0] SEG_GAP       = 8'd131;
  localparam logic [SEG_W-1:0] SEG_COUNT     = 8'd132;

  localparam logic [CFG_IDX_W-1:0] CFG_SHORT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT = 2'd3;

  localparam logic [SHORT_W-1:0] SHORT_RST  = 12'd275;
  localparam logic [LONG_W-1:0]  LONG_RST   = 13'd1240;
  localparam logic [GAP_W-1:0]   GAP_RST    = 16'd10000;
  localparam logic [RPT_W-1:0]   REPEAT_RST = 4'd5;

  typedef struct packed {
    logic             cmd;
    logic [ID_W-1:0]  transmitter_id;
    logic             switch_on;
    logic [DEV_W-1:0] device_number;
  } in_beat_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic sequence_done;
  } out_beat_t;

  typedef struct packed {
    logic [SHORT_W-1:0] short_pulse_ticks;
    logic [LONG_W-1:0]  long_pulse_ticks;
    logic [GAP_W-1:0]   gap_ticks;
    logic [RPT_W-1:0]   repeat_count;
  } cfg_t;

  typedef struct packed {
    logic             ok;
    logic [SEG_W-1:0] seg;
    logic [DUR_W-1:0] dur;
    logic [RPT_W-1:0] repeats;
  } settle_t;

  function automatic logic seg_level(input logic [SEG_W-1:0] idx);
    logic lvl;
    if (idx == SEG_HDR_HI || idx == SEG_FOOTER) begin
      lvl = 1'b1;
    end else if (idx == SEG_HDR_LO || idx >= SEG_GAP) begin
      lvl = 1'b0;
    end else begin
      lvl = ~idx[0];
    end
    return lvl;
  endfunction

  function automatic logic [DUR_W-1:0] seg_dur(input logic [SEG_W-1:0]   idx,
                                               input logic [FRAME_W-1:0] frame,
                                               input cfg_t               cfg);
    logic [SEG_W-1:0] k;
    logic             pbit;
    logic [DUR_W-1:0] s_dur;
    logic [DUR_W-1:0] l_dur;
    logic [DUR_W-1:0] d;
    s_dur = DUR_W'(cfg.short_pulse_ticks);
    l_dur = DUR_W'(cfg.long_pulse_ticks);
    k     = idx - SEG_FIRST_BIT;
    pbit  = frame[~k[6:2]] ^ k[1];
    if (idx == SEG_HDR_HI || idx == SEG_FOOTER) begin
      d = s_dur;
    end else if (idx == SEG_HDR_LO) begin
      d = {l_dur[DUR_W-2:0], 1'b0};
    end else if (idx >= SEG_GAP) begin
      d = DUR_W'(cfg.gap_ticks);
    end else if (!k[0]) begin
      d = s_dur;
    end else begin
      d = pbit ? l_dur : s_dur;
    end
    return d;
  endfunction

endpackage

// ===== hw/rtl/ooktx_if.sv =====
interface ooktx_in_if;
  import ooktx_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ooktx_out_if;
  import ooktx_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/ooktx_cfg_regs.sv =====
module ooktx_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                we_i,
  input  logic [ooktx_pkg::CFG_IDX_W-1:0]     idx_i,
  input  logic [ooktx_pkg::CFG_DATA_W-1:0]    data_i,
  output ooktx_pkg::cfg_t                     cfg_o
);
  import ooktx_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        CFG_SHORT:  cfg_d.short_pulse_ticks = data_i[SHORT_W-1:0];
        CFG_LONG:   cfg_d.long_pulse_ticks  = data_i[LONG_W-1:0];
        CFG_GAP:    cfg_d.gap_ticks         = data_i[GAP_W-1:0];
        CFG_REPEAT: cfg_d.repeat_count      = data_i[RPT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{SHORT_RST, LONG_RST, GAP_RST, REPEAT_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/ooktx_settle.sv =====
module ooktx_settle (
  input  logic [ooktx_pkg::SEG_W-1:0]   idx_i,
  input  logic [ooktx_pkg::FRAME_W-1:0] frame_i,
  input  logic [ooktx_pkg::RPT_W-1:0]   repeats_i,
  input  ooktx_pkg::cfg_t               cfg_i,
  output ooktx_pkg::settle_t            res_o
);
  import ooktx_pkg::*;

  logic [SEG_W:0]   cand_sum  [WIN];
  logic [SEG_W-1:0] cand_idx  [WIN];
  logic             cand_wrap [WIN];
  logic [DUR_W-1:0] cand_dur  [WIN];
  logic             found;

  always_comb begin
    for (int c = 0; c < WIN; c++) begin
      cand_sum[c]  = {1'b0, idx_i} + (SEG_W+1)'(c);
      cand_wrap[c] = cand_sum[c] >= {1'b0, SEG_COUNT};
      cand_idx[c]  = cand_wrap[c] ? SEG_W'(cand_sum[c] - {1'b0, SEG_COUNT})
                                  : cand_sum[c][SEG_W-1:0];
      cand_dur[c]  = seg_dur(cand_idx[c], frame_i, cfg_i);
    end
  end

  // With no short and no long pulse only the gap carries time.
  always_comb begin
    res_o = '0;
    found = 1'b0;
    if (cfg_i.short_pulse_ticks == '0 && cfg_i.long_pulse_ticks == '0) begin
      if (cfg_i.gap_ticks != '0) begin
        if (idx_i <= SEG_GAP) begin
          res_o.ok      = 1'b1;
          res_o.seg     = SEG_GAP;
          res_o.dur     = DUR_W'(cfg_i.gap_ticks);
          res_o.repeats = repeats_i;
        end else if (repeats_i > RPT_W'(1)) begin
          res_o.ok      = 1'b1;
          res_o.seg     = SEG_GAP;
          res_o.dur     = DUR_W'(cfg_i.gap_ticks);
          res_o.repeats = repeats_i - RPT_W'(1);
        end
      end
    end else begin
      for (int c = 0; c < WIN; c++) begin
        if (!found && cand_dur[c] != '0) begin
          found = 1'b1;
          if (!cand_wrap[c]) begin
            res_o.ok      = 1'b1;
            res_o.seg     = cand_idx[c];
            res_o.dur     = cand_dur[c];
            res_o.repeats = repeats_i;
          end else if (repeats_i > RPT_W'(1)) begin
            res_o.ok      = 1'b1;
            res_o.seg     = cand_idx[c];
            res_o.dur     = cand_dur[c];
            res_o.repeats = repeats_i - RPT_W'(1);
          end
        end
      end
    end
  end

endmodule

// ===== hw/rtl/ook_remote_frame_transmitter_core.sv =====
// channel  dir  beat fields
// in_i     in   cmd, transmitter_id, switch_on, device_number
// out_o    out  line_level, busy_res, sequence_done
// cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// One input beat per cycle while ready; each yields one output beat next cycle.
// The sequencer state and the output register update in the cycle of acceptance.
// Reset loads the default timing registers and leaves the line idle.
// A stalled output holds in_i.ready low until the waiting beat is taken.
module ook_remote_frame_transmitter_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ooktx_in_if.sink                          in_i,
  ooktx_out_if.source                       out_o,
  input  logic                              cfg_we_i,
  input  logic [ooktx_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ooktx_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import ooktx_pkg::*;

  cfg_t             cfg;
  settle_t          first_res;
  settle_t          next_res;

  logic             active_q, active_d;
  logic [SEG_W-1:0] seg_q, seg_d;
  logic [DUR_W-1:0] dur_q, dur_d;
  logic [RPT_W-1:0] rep_q, rep_d;
  logic [FRAME_W-1:0] frame_q, frame_d;
  out_beat_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic             accept;
  logic             start;
  logic [FRAME_W-1:0] frame_new;
  logic [RPT_W-1:0] rep_start;

  logic             a_active;
  logic             a_done;
  logic [SEG_W-1:0] a_seg;
  logic [DUR_W-1:0] a_dur;
  logic [RPT_W-1:0] a_rep;
  logic [FRAME_W-1:0] a_frame;
  logic [DUR_W-1:0] dur_dec;
  logic [SEG_W-1:0] next_idx;

  ooktx_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign start      = in_i.payload.cmd && !active_q;
  assign frame_new  = {~in_i.payload.transmitter_id, 1'b0, in_i.payload.switch_on,
                       in_i.payload.device_number};
  assign rep_start  = (cfg.repeat_count == '0) ? RPT_W'(1) : cfg.repeat_count;

  ooktx_settle u_first (
    .idx_i     (SEG_HDR_HI),
    .frame_i   (frame_new),
    .repeats_i (rep_start),
    .cfg_i     (cfg),
    .res_o     (first_res)
  );

  always_comb begin
    if (start) begin
      a_active = first_res.ok;
      a_done   = !first_res.ok;
      a_seg    = first_res.seg;
      a_dur    = first_res.dur;
      a_rep    = first_res.repeats;
      a_frame  = frame_new;
    end else begin
      a_active = active_q;
      a_done   = 1'b0;
      a_seg    = seg_q;
      a_dur    = dur_q;
      a_rep    = rep_q;
      a_frame  = frame_q;
    end
  end

  assign dur_dec  = a_dur - DUR_W'(1);
  assign next_idx = a_seg + SEG_W'(1);

  ooktx_settle u_next (
    .idx_i     (next_idx),
    .frame_i   (a_frame),
    .repeats_i (a_rep),
    .cfg_i     (cfg),
    .res_o     (next_res)
  );

  always_comb begin
    active_d    = active_q;
    seg_d       = seg_q;
    dur_d       = dur_q;
    rep_d       = rep_q;
    frame_d     = frame_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (accept) begin
      active_d    = a_active;
      seg_d       = a_seg;
      dur_d       = a_dur;
      rep_d       = a_rep;
      frame_d     = a_frame;
      out_d       = '{1'b0, 1'b0, a_done};
      out_valid_d = 1'b1;
      if (a_active) begin
        out_d.line_level = seg_level(a_seg);
        out_d.busy_res   = 1'b1;
        dur_d            = dur_dec;
        if (dur_dec == '0) begin
          if (next_res.ok) begin
            seg_d = next_res.seg;
            dur_d = next_res.dur;
            rep_d = next_res.repeats;
          end else begin
            active_d            = 1'b0;
            seg_d               = '0;
            rep_d               = '0;
            out_d.sequence_done = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      seg_q       <= '0;
      dur_q       <= '0;
      rep_q       <= '0;
      frame_q     <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      seg_q       <= seg_d;
      dur_q       <= dur_d;
      rep_q       <= rep_d;
      frame_q     <= frame_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule
